// ===== src/umt_pkg.sv =====
package umt_pkg;

   localparam logic [7:0] LEAD_C3   = 8'hC3;
   localparam logic [7:0] LEAD_C2   = 8'hC2;
   localparam logic [7:0] ASCII_TOP = 8'h80;
   localparam logic [7:0] CONT_MASK = 8'hC0;
   localparam logic [7:0] CONT_TAG  = 8'h80;
   localparam logic [7:0] QMARK     = 8'h3F;
   localparam logic [7:0] END_BYTE  = 8'h00;

   localparam logic KIND_CHAR = 1'b0;
   localparam logic KIND_END  = 1'b1;

   localparam logic [15:0] MAX_CHARS_RESET = 16'd255;
   localparam int unsigned MAX_RESULTS     = 3;

   typedef enum logic [1:0] {
      MODE_NORMAL   = 2'd0,
      MODE_AFTER_C3 = 2'd1,
      MODE_AFTER_C2 = 2'd2,
      MODE_SWALLOW  = 2'd3
   } mode_type;

   typedef enum logic [0:0] {
      REG_MAX_CHARS = 1'b0,
      REG_NONE      = 1'b1
   } reg_index_type;

   typedef struct packed {
      logic [7:0]  out_byte;
      logic        out_kind;
      logic [15:0] out_count;
   } result_type;

   typedef struct packed {
      logic [1:0]                        count;
      result_type [MAX_RESULTS-1:0]      items;
   } bundle_type;

   typedef struct packed {
      logic       ok;
      logic [7:0] first;
      logic [7:0] second;
   } spelling_type;

   function automatic spelling_type umlaut_spelling(input logic [7:0] code);
      spelling_type sp;
      sp = '{ok: 1'b1, first: 8'h00, second: 8'h65};
      unique case (code)
         8'hA4:   sp.first = 8'h61;
         8'hB6:   sp.first = 8'h6F;
         8'hBC:   sp.first = 8'h75;
         8'h84:   sp.first = 8'h41;
         8'h96:   sp.first = 8'h4F;
         8'h9C:   sp.first = 8'h55;
         8'h9F: begin
            sp.first  = 8'h73;
            sp.second = 8'h73;
         end
         default: sp.ok = 1'b0;
      endcase
      return sp;
   endfunction

endpackage

// ===== src/umt_req_if.sv =====
interface umt_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       in_last;

   modport source (output valid, output in_byte, output in_last, input ready);
   modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

// ===== src/umt_rsp_if.sv =====
interface umt_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  out_byte;
   logic        out_kind;
   logic [15:0] out_count;

   modport source (output valid, output out_byte, output out_kind, output out_count,
                   input ready);
   modport sink   (input valid, input out_byte, input out_kind, input out_count,
                   output ready);
endinterface

// ===== src/umt_csr.sv =====
module umt_csr (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready,
   output logic [15:0] max_chars
);
   import umt_pkg::*;

   logic [15:0]   max_chars_ff;
   logic [15:0]   max_chars_in;
   reg_index_type reg_index;
   logic          write_beat;

   assign reg_index  = reg_index_type'(csr_paddr[2]);
   assign csr_pready = 1'b1;
   assign write_beat = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_comb begin
      max_chars_in = max_chars_ff;
      if (write_beat && reg_index == REG_MAX_CHARS) begin
         max_chars_in = csr_pwdata[15:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_chars_ff <= MAX_CHARS_RESET;
      end else begin
         max_chars_ff <= max_chars_in;
      end
   end

   always_comb begin
      unique case (reg_index)
         REG_MAX_CHARS: csr_prdata = {16'h0000, max_chars_ff};
         default:       csr_prdata = 32'h0000_0000;
      endcase
   end

   assign max_chars = max_chars_ff;
endmodule

// ===== src/umt_decode.sv =====
module umt_decode (
   input  logic                clock,
   input  logic                reset,
   umt_req_if.sink             req_chan,
   input  logic [15:0]         max_chars,
   input  logic                can_take,
   output logic                load,
   output umt_pkg::bundle_type bundle
);
   import umt_pkg::*;

   logic        in_valid_ff;
   logic        in_valid_in;
   logic [7:0]  in_byte_ff;
   logic        in_last_ff;
   mode_type    mode_ff;
   mode_type    mode_in;
   logic [15:0] count_ff;
   logic [15:0] count_in;

   logic         fire;
   logic         req_beat;
   mode_type     mode_dec;
   logic         lead;
   logic [1:0]   want;
   logic [7:0]   char0;
   logic [7:0]   char1;
   spelling_type sp;
   logic [16:0]  count_wide;
   logic         put0;
   logic         put1;
   logic [1:0]   nchars;
   logic [15:0]  count_next;

   assign fire           = in_valid_ff & can_take;
   assign req_chan.ready = ~in_valid_ff | fire;
   assign req_beat       = req_chan.valid & req_chan.ready;
   assign in_valid_in    = req_beat | (in_valid_ff & ~fire);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_beat) begin
         in_byte_ff <= req_chan.in_byte;
         in_last_ff <= req_chan.in_last;
      end
   end

   always_comb begin
      sp       = umlaut_spelling(in_byte_ff);
      mode_dec = mode_ff;
      lead     = 1'b0;
      want     = 2'd0;
      char0    = QMARK;
      char1    = QMARK;
      unique case (mode_ff)
         MODE_AFTER_C3: begin
            mode_dec = MODE_NORMAL;
            if (sp.ok) begin
               want  = 2'd2;
               char0 = sp.first;
               char1 = sp.second;
            end else begin
               want = 2'd1;
            end
         end
         MODE_AFTER_C2: begin
            mode_dec = MODE_NORMAL;
            want     = 2'd1;
            char0    = in_byte_ff;
         end
         MODE_SWALLOW: begin
            if ((in_byte_ff & CONT_MASK) != CONT_TAG) begin
               mode_dec = MODE_NORMAL;
               lead     = 1'b1;
            end
         end
         default: lead = 1'b1;
      endcase
      if (lead) begin
         if (in_byte_ff < ASCII_TOP) begin
            want  = 2'd1;
            char0 = in_byte_ff;
         end else if (in_byte_ff == LEAD_C3 || in_byte_ff == LEAD_C2) begin
            if (in_last_ff) begin
               want = 2'd1;
            end else if (in_byte_ff == LEAD_C3) begin
               mode_dec = MODE_AFTER_C3;
            end else begin
               mode_dec = MODE_AFTER_C2;
            end
         end else begin
            want     = 2'd1;
            mode_dec = MODE_SWALLOW;
         end
      end
   end

   assign count_wide = {1'b0, count_ff};
   assign put0       = (want != 2'd0) && (count_wide < {1'b0, max_chars});
   assign put1       = (want == 2'd2) && ((count_wide + 17'd1) < {1'b0, max_chars});
   assign nchars     = {1'b0, put0} + {1'b0, put1};
   assign count_next = count_ff + {14'd0, nchars};

   always_comb begin
      bundle = '0;
      bundle.items[0] = '{out_byte: char0, out_kind: KIND_CHAR, out_count: 16'd0};
      bundle.items[1] = '{out_byte: char1, out_kind: KIND_CHAR, out_count: 16'd0};
      if (in_last_ff) begin
         bundle.items[nchars] = '{out_byte: END_BYTE, out_kind: KIND_END,
                                  out_count: count_next};
      end
      bundle.count = nchars + {1'b0, in_last_ff};
   end

   assign load = fire && (bundle.count != 2'd0);

   always_comb begin
      mode_in  = mode_ff;
      count_in = count_ff;
      if (fire) begin
         if (in_last_ff) begin
            mode_in  = MODE_NORMAL;
            count_in = 16'd0;
         end else begin
            mode_in  = mode_dec;
            count_in = count_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_NORMAL;
         count_ff <= 16'd0;
      end else begin
         mode_ff  <= mode_in;
         count_ff <= count_in;
      end
   end
endmodule

// ===== src/umt_result_buffer.sv =====
module umt_result_buffer (
   input  logic                clock,
   input  logic                reset,
   input  logic                load,
   input  umt_pkg::bundle_type bundle,
   output logic                can_take,
   umt_rsp_if.source           rsp_chan
);
   import umt_pkg::*;

   bundle_type bundle_ff;
   logic       full_ff;
   logic       full_in;
   logic [1:0] idx_ff;
   logic [1:0] idx_in;
   logic       rsp_beat;
   logic       final_beat;
   result_type head;

   assign head       = bundle_ff.items[idx_ff];
   assign rsp_beat   = full_ff & rsp_chan.ready;
   assign final_beat = rsp_beat && (idx_ff == bundle_ff.count - 2'd1);
   assign can_take   = ~full_ff | final_beat;

   assign rsp_chan.valid     = full_ff;
   assign rsp_chan.out_byte  = head.out_byte;
   assign rsp_chan.out_kind  = head.out_kind;
   assign rsp_chan.out_count = head.out_count;

   always_comb begin
      full_in = full_ff;
      idx_in  = idx_ff;
      priority if (load) begin
         full_in = 1'b1;
         idx_in  = 2'd0;
      end else if (final_beat) begin
         full_in = 1'b0;
         idx_in  = 2'd0;
      end else if (rsp_beat) begin
         idx_in = idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         full_ff <= 1'b0;
         idx_ff  <= 2'd0;
      end else begin
         full_ff <= full_in;
         idx_ff  <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         bundle_ff <= bundle;
      end
   end
endmodule

// ===== src/utf8_umlaut_transliterator.sv =====
// A byte beat is captured in the input register; its results are then loaded
// into the result register once earlier results there have all been taken.
// Throughput is one byte per cycle while the result register is free; a byte
// yielding k results holds it until all k are taken. Synchronous active-high
// reset empties both registers, clears the decode mode and character count,
// and sets max_chars to 255.
module utf8_umlaut_transliterator (
   input  logic        clock,
   input  logic        reset,
   umt_req_if.sink     req_chan,
   umt_rsp_if.source   rsp_chan,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import umt_pkg::*;

   logic [15:0] max_chars;
   logic        can_take;
   logic        load;
   bundle_type  bundle;

   umt_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .max_chars   (max_chars)
   );

   umt_decode u_decode (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .max_chars (max_chars),
      .can_take  (can_take),
      .load      (load),
      .bundle    (bundle)
   );

   umt_result_buffer u_result_buffer (
      .clock    (clock),
      .reset    (reset),
      .load     (load),
      .bundle   (bundle),
      .can_take (can_take),
      .rsp_chan (rsp_chan)
   );

   // The input side stalls only when both the input and result registers hold work.
   a_stall_needs_result: assert property (@(posedge clock) disable iff (reset)
      !req_chan.ready |-> rsp_chan.valid)
      else $error("input stalled with no result pending");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_chan.valid && req_chan.ready)
      else $error("block not empty after reset");

   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      load |-> can_take)
      else $error("result register loaded while occupied");
endmodule

// ===== tb/utf8_umlaut_transliterator_tb.sv =====
module utf8_umlaut_transliterator_tb;
   import umt_pkg::*;

   localparam logic [2:0] MAX_CHARS_ADDR = {REG_MAX_CHARS, 2'b00};
   localparam logic [6:0][7:0] UMLAUT_CODES =
      {8'hA4, 8'hB6, 8'hBC, 8'h84, 8'h96, 8'h9C, 8'h9F};

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [2:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   umt_req_if req_chan();
   umt_rsp_if rsp_chan();

   utf8_umlaut_transliterator DUT (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #4 clock = ~clock;

   mode_type    decode_state  = MODE_NORMAL;
   logic [15:0] chars_written = 16'd0;
   logic [15:0] char_limit    = MAX_CHARS_RESET;
   result_type  expected_chars[$];
   result_type  oldest_char;
   logic [7:0]  text_bytes[$];
   int          errors             = 0;
   int          bytes_sent         = 0;
   int          sender_idle_pct    = 0;
   int          receiver_stall_pct = 0;

   function automatic void emit_char(input logic [7:0] c);
      if (chars_written < char_limit) begin
         expected_chars.push_back('{out_byte: c, out_kind: KIND_CHAR, out_count: 16'd0});
         chars_written = chars_written + 16'd1;
      end
   endfunction

   function automatic void decode_lead(input logic [7:0] b, input logic last);
      if (b < ASCII_TOP) begin
         emit_char(b);
      end else if (b == LEAD_C3 || b == LEAD_C2) begin
         if (last) begin
            emit_char(QMARK);
         end else begin
            decode_state = (b == LEAD_C3) ? MODE_AFTER_C3 : MODE_AFTER_C2;
         end
      end else begin
         emit_char(QMARK);
         decode_state = MODE_SWALLOW;
      end
   endfunction

   function automatic void transliterate(input logic [7:0] b, input logic last);
      logic [7:0] first;
      logic [7:0] second;
      first  = 8'h00;
      second = "e";
      case (decode_state)
         MODE_AFTER_C3: begin
            decode_state = MODE_NORMAL;
            case (b)
               8'hA4: first = "a";
               8'hB6: first = "o";
               8'hBC: first = "u";
               8'h84: first = "A";
               8'h96: first = "O";
               8'h9C: first = "U";
               8'h9F: begin
                  first  = "s";
                  second = "s";
               end
               default: first = 8'h00;
            endcase
            if (first == 8'h00) begin
               emit_char(QMARK);
            end else begin
               emit_char(first);
               emit_char(second);
            end
         end
         MODE_AFTER_C2: begin
            decode_state = MODE_NORMAL;
            emit_char(b);
         end
         MODE_SWALLOW: begin
            if ((b & CONT_MASK) != CONT_TAG) begin
               decode_state = MODE_NORMAL;
               decode_lead(b, last);
            end
         end
         default: decode_lead(b, last);
      endcase
      if (last) begin
         expected_chars.push_back('{out_byte: END_BYTE, out_kind: KIND_END,
                                    out_count: chars_written});
         decode_state  = MODE_NORMAL;
         chars_written = 16'd0;
      end
   endfunction

   always @(posedge clock) begin
      rsp_chan.ready <= !reset && ($urandom_range(99) >= receiver_stall_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (expected_chars.size() == 0) begin
            $display("%0t: unexpected beat, expected none, got byte %h kind %b count %0d",
                     $time, rsp_chan.out_byte, rsp_chan.out_kind, rsp_chan.out_count);
            errors++;
         end else begin
            oldest_char = expected_chars.pop_front();
            if (rsp_chan.out_byte !== oldest_char.out_byte) begin
               $display("%0t: out_byte expected %h, got %h",
                        $time, oldest_char.out_byte, rsp_chan.out_byte);
               errors++;
            end
            if (rsp_chan.out_kind !== oldest_char.out_kind) begin
               $display("%0t: out_kind expected %b, got %b",
                        $time, oldest_char.out_kind, rsp_chan.out_kind);
               errors++;
            end
            if (rsp_chan.out_count !== oldest_char.out_count) begin
               $display("%0t: out_count expected %0d, got %0d",
                        $time, oldest_char.out_count, rsp_chan.out_count);
               errors++;
            end
         end
      end
   end

   task automatic send_byte(input logic [7:0] value, input logic last);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid   <= 1'b1;
      req_chan.in_byte <= value;
      req_chan.in_last <= last;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      transliterate(value, last);
      bytes_sent++;
   endtask

   task automatic send_text();
      for (int i = 0; i < text_bytes.size(); i++) begin
         send_byte(text_bytes[i], i == text_bytes.size() - 1);
      end
      text_bytes.delete();
   endtask

   task automatic finish_phase();
      req_chan.valid <= 1'b0;
      while (expected_chars.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic check_max_chars();
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= MAX_CHARS_ADDR;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      if (csr_prdata !== {16'd0, char_limit}) begin
         $display("%0t: max_chars readback expected %h, got %h",
                  $time, {16'd0, char_limit}, csr_prdata);
         errors++;
      end
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic set_max_chars(input logic [15:0] value);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= MAX_CHARS_ADDR;
      csr_pwdata  <= {16'd0, value};
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      char_limit = value;
      check_max_chars();
   endtask

   task automatic build_random_text();
      int         kind;
      logic [7:0] lead;
      repeat ($urandom_range(1, 6)) begin
         kind = $urandom_range(0, 9);
         case (kind)
            0, 1, 2, 3: text_bytes.push_back(8'($urandom_range(1, 127)));
            4, 5: begin
               text_bytes.push_back(LEAD_C3);
               text_bytes.push_back(UMLAUT_CODES[$urandom_range(0, 6)]);
            end
            6: begin
               text_bytes.push_back(LEAD_C3);
               text_bytes.push_back(8'($urandom_range(1, 255)));
            end
            7: begin
               text_bytes.push_back(LEAD_C2);
               text_bytes.push_back(8'($urandom_range(1, 255)));
            end
            8: begin
               do begin
                  lead = 8'($urandom_range(128, 255));
               end while (lead == LEAD_C2 || lead == LEAD_C3);
               text_bytes.push_back(lead);
               repeat ($urandom_range(0, 3)) text_bytes.push_back(8'($urandom_range(128, 191)));
            end
            default: text_bytes.push_back($urandom_range(0, 1) ? LEAD_C3 : LEAD_C2);
         endcase
      end
   endtask

   task automatic test_register_reset();
      @(posedge clock);
      check_max_chars();
   endtask

   task automatic test_passthrough_and_umlauts();
      text_bytes = '{8'h01, 8'h7F,
                     LEAD_C3, 8'hA4, LEAD_C3, 8'hB6, LEAD_C3, 8'hBC, LEAD_C3, 8'h84,
                     LEAD_C3, 8'h96, LEAD_C3, 8'h9C, LEAD_C3, 8'h9F, LEAD_C3, 8'hFF};
      send_text();
      finish_phase();
   endtask

   task automatic test_raw_swallow_and_bare_lead();
      text_bytes = '{LEAD_C2, 8'h80, 8'hFF, 8'h80, 8'hBF, 8'h41, LEAD_C3};
      send_text();
      finish_phase();
   endtask

   task automatic test_char_limit();
      set_max_chars(16'd3);
      text_bytes = '{LEAD_C3, 8'hA4, LEAD_C2};
      send_text();
      finish_phase();
      set_max_chars(16'd0);
      text_bytes = '{8'h41};
      send_text();
      finish_phase();
   endtask

   task automatic test_random_text(input logic [15:0] limit, input int idle_pct,
                                   input int stall_pct);
      int stop_at;
      set_max_chars(limit);
      sender_idle_pct    = idle_pct;
      receiver_stall_pct = stall_pct;
      stop_at            = bytes_sent + 20;
      while (bytes_sent < stop_at) begin
         build_random_text();
         send_text();
      end
      finish_phase();
   endtask

   initial begin
      req_chan.valid   = 1'b0;
      req_chan.in_byte = 8'h01;
      req_chan.in_last = 1'b0;
      rsp_chan.ready   = 1'b0;
      csr_psel         = 1'b0;
      csr_penable      = 1'b0;
      csr_pwrite       = 1'b0;
      csr_paddr        = MAX_CHARS_ADDR;
      csr_pwdata       = 32'd0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      test_register_reset();
      test_passthrough_and_umlauts();
      test_raw_swallow_and_bare_lead();
      test_char_limit();
      test_random_text(16'hFFFF, 0, 0);
      test_random_text(16'd4, 70, 0);
      test_random_text(16'd0, 0, 70);
      test_random_text(16'($urandom_range(1, 12)), 34, 34);
      repeat (4) @(posedge clock);
      if (errors == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   initial begin
      #800000;
      $display("CHECK FAILED");
      $finish;
   end

endmodule

// ===== sim.f =====
src/umt_pkg.sv
src/umt_req_if.sv
src/umt_rsp_if.sv
src/umt_csr.sv
src/umt_decode.sv
src/umt_result_buffer.sv
src/utf8_umlaut_transliterator.sv
tb/utf8_umlaut_transliterator_tb.sv
